// ===== hdl/tun_pkg.sv =====
// Shared widths, cell word type and helpers for the triangle unit normal block.
// Used by every module under hdl; no other dependencies.
package tun_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int OUT_W       = 32;
    localparam int OUT_FRAC    = 30;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int MAG_W       = 2 * DIFF_W;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int NUM_W       = SQ_W + 2 * OUT_FRAC;
    localparam int Q_W         = 2 * OUT_FRAC + 2;
    localparam int DIV_CELLS   = Q_W;
    localparam int R_W         = OUT_FRAC + 1;
    localparam int SQRT_CELLS  = Q_W / 2;

    // Word handed along the divide chain: one lane per component.
    typedef struct packed {
        logic                 vld;
        logic                 degen;
        logic [2:0]           neg;
        logic [SUM_W-1:0]     den;
        logic [2:0][NUM_W-1:0] num;
        logic [2:0][SUM_W:0]  rem;
        logic [2:0][Q_W-1:0]  quo;
    } t_div_word;

    // Word handed along the square root chain.
    typedef struct packed {
        logic                 vld;
        logic                 degen;
        logic [2:0]           neg;
        logic [2:0][Q_W-1:0]  rad;
        logic [2:0][R_W+1:0]  rem;
        logic [2:0][R_W-1:0]  root;
    } t_sqrt_word;
endpackage

// ===== hdl/tun_div_cell.sv =====
// One restoring divide step per lane: shift in a numerator bit, compare, subtract.
// Depends on tun_pkg.
module tun_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tun_pkg::t_div_word i_word,
    output tun_pkg::t_div_word o_word
);
    import tun_pkg::*;

    t_div_word r_word;
    t_div_word n_word;

    // One quotient bit for each lane.
    always_comb begin
        logic [SUM_W+1:0] trial;
        n_word = i_word;
        for (int l = 0; l < 3; l++) begin
            trial = {i_word.rem[l], i_word.num[l][NUM_W-1]};
            n_word.num[l] = {i_word.num[l][NUM_W-2:0], 1'b0};
            if (trial >= {2'b00, i_word.den}) begin
                trial = trial - {2'b00, i_word.den};
                n_word.quo[l] = {i_word.quo[l][Q_W-2:0], 1'b1};
            end else begin
                n_word.quo[l] = {i_word.quo[l][Q_W-2:0], 1'b0};
            end
            n_word.rem[l] = trial[SUM_W:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end
    end

    assign o_word = r_word;
endmodule

// ===== hdl/tun_sqrt_cell.sv =====
// One digit-by-digit square root step per lane: two radicand bits in, one root bit out.
// Depends on tun_pkg.
module tun_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tun_pkg::t_sqrt_word i_word,
    output tun_pkg::t_sqrt_word o_word
);
    import tun_pkg::*;

    t_sqrt_word r_word;
    t_sqrt_word n_word;

    always_comb begin
        logic [R_W+3:0] trial;
        logic [R_W+3:0] cur;
        n_word = i_word;
        for (int l = 0; l < 3; l++) begin
            cur   = {i_word.rem[l], i_word.rad[l][Q_W-1:Q_W-2]};
            trial = {1'b0, i_word.root[l], 2'b01};
            n_word.rad[l] = {i_word.rad[l][Q_W-3:0], 2'b00};
            if (cur >= trial) begin
                cur = cur - trial;
                n_word.root[l] = {i_word.root[l][R_W-2:0], 1'b1};
            end else begin
                n_word.root[l] = {i_word.root[l][R_W-2:0], 1'b0};
            end
            n_word.rem[l] = cur[R_W+1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end
    end

    assign o_word = r_word;
endmodule

// ===== hdl/tun_front.sv =====
// Front stages: edges, cross product in partial products, squares and their sum.
// Depends on tun_pkg; feeds the divide chain with a t_div_word.
module tun_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [tun_pkg::OUT_W-1:0]    i_crd [9],
    output tun_pkg::t_div_word           o_word
);
    import tun_pkg::*;

    localparam int H = MAG_W / 2;

    // Stage 1: edges.
    logic                     r1_vld;
    logic signed [DIFF_W-1:0] r1_u [3];
    logic signed [DIFF_W-1:0] r1_v [3];
    // Stage 2: the six products as magnitudes with signs.
    logic                     r2_vld;
    logic [MAG_W-1:0]         r2_p [6];
    logic                     r2_s [6];
    // Stage 3: signed cross components.
    logic                     r3_vld;
    logic [MAG_W-1:0]         r3_m [3];
    logic                     r3_n [3];
    // Stage 4 and 5: partial products of the 33-bit halves, then squares.
    logic                     r4_vld;
    logic [MAG_W-1:0]         r4_pp [3][4];
    logic                     r4_n [3];
    logic                     r5_vld;
    logic [SQ_W-1:0]          r5_sq [3];
    logic                     r5_n [3];
    t_div_word                r6_word;

    function automatic logic signed [DIFF_W-1:0] crd(input logic [OUT_W-1:0] v);
        return DIFF_W'(signed'(v[COORD_WIDTH-1:0]));
    endfunction

    function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        logic [MAG_W:0] d;
        r1_vld <= i_vld;
        for (int k = 0; k < 3; k++) begin
            r1_u[k] <= crd(i_crd[6+k]) - crd(i_crd[3+k]);
            r1_v[k] <= crd(i_crd[k]) - crd(i_crd[3+k]);
        end
        // Products: x=uy*vz - uz*vy, y=uz*vx - ux*vz, z=ux*vy - uy*vx.
        r2_vld <= r1_vld;
        for (int k = 0; k < 3; k++) begin
            r2_p[2*k]   <= mag(r1_u[(k+1)%3]) * mag(r1_v[(k+2)%3]);
            r2_s[2*k]   <= r1_u[(k+1)%3][DIFF_W-1] ^ r1_v[(k+2)%3][DIFF_W-1];
            r2_p[2*k+1] <= mag(r1_u[(k+2)%3]) * mag(r1_v[(k+1)%3]);
            r2_s[2*k+1] <= ~(r1_u[(k+2)%3][DIFF_W-1] ^ r1_v[(k+1)%3][DIFF_W-1]);
        end
        r3_vld <= r2_vld;
        for (int k = 0; k < 3; k++) begin
            d = {1'b0, r2_p[2*k]} - {1'b0, r2_p[2*k+1]};
            if (r2_s[2*k] == r2_s[2*k+1]) begin
                r3_m[k] <= r2_p[2*k] + r2_p[2*k+1];
                r3_n[k] <= r2_s[2*k];
            end else if (!d[MAG_W]) begin
                r3_m[k] <= d[MAG_W-1:0];
                r3_n[k] <= r2_s[2*k];
            end else begin
                r3_m[k] <= MAG_W'(-d);
                r3_n[k] <= r2_s[2*k+1];
            end
        end
        r4_vld <= r3_vld;
        for (int k = 0; k < 3; k++) begin
            r4_pp[k][0] <= r3_m[k][H-1:0] * r3_m[k][H-1:0];
            r4_pp[k][1] <= r3_m[k][H-1:0] * r3_m[k][MAG_W-1:H];
            r4_pp[k][2] <= r3_m[k][MAG_W-1:H] * r3_m[k][MAG_W-1:H];
            r4_pp[k][3] <= r3_m[k];
            r4_n[k]     <= r3_n[k];
        end
        r5_vld <= r4_vld;
        for (int k = 0; k < 3; k++) begin
            r5_sq[k] <= SQ_W'(r4_pp[k][0]) + (SQ_W'(r4_pp[k][1]) << (H + 1))
                      + (SQ_W'(r4_pp[k][2]) << (2 * H));
            r5_n[k]  <= r4_n[k] && (r4_pp[k][3] != '0);
        end
        r6_word.vld   <= r5_vld;
        r6_word.den   <= SUM_W'(r5_sq[0]) + SUM_W'(r5_sq[1]) + SUM_W'(r5_sq[2]);
        r6_word.degen <= (r5_sq[0] == '0) && (r5_sq[1] == '0) && (r5_sq[2] == '0);
        // The numerator is n_i^2 * 2^60. Its part above the low Q_W bits is n_i^2 / 4,
        // which is already below S, so it starts as the remainder and the chain
        // only has to walk the low Q_W numerator bits.
        for (int k = 0; k < 3; k++) begin
            r6_word.neg[k] <= r5_n[k];
            r6_word.num[k] <= {r5_sq[k][1:0], {(NUM_W-2){1'b0}}};
            r6_word.rem[k] <= (SUM_W+1)'(r5_sq[k][SQ_W-1:2]);
            r6_word.quo[k] <= '0;
        end
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_word.vld <= 1'b0;
        end
    end

    assign o_word = r6_word;
endmodule

// ===== hdl/triangle_unit_normal.sv =====
// Top level of the triangle unit normal block: front stages, divide and root chains.
// Depends on tun_pkg, tun_front, tun_div_cell and tun_sqrt_cell.
//
// Usage: drive the nine vertex coordinates (signed Q16.16) and raise i_start.
// o_busy stays low, so a word is taken at every clock edge with i_start high:
// one triangle per cycle, sustained.
// Each word comes back as one result word, in order, after passing through six
// front stages (edges, products, cross terms, partial squares, squares, sum), one
// divide cell per quotient bit of n_i^2 * 2^60 / S, one root cell per root bit,
// and the output register. The divide chain is the longest part of the pipeline.
// o_done marks the result for exactly one cycle; the receiver cannot stall,
// and none is needed. o_norm_* are signed Q2.30; o_degenerate flags zero length.
// Synchronous reset empties the pipeline; words in flight are dropped.
module triangle_unit_normal (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_a_x,
    input  logic [31:0] i_a_y,
    input  logic [31:0] i_a_z,
    input  logic [31:0] i_b_x,
    input  logic [31:0] i_b_y,
    input  logic [31:0] i_b_z,
    input  logic [31:0] i_c_x,
    input  logic [31:0] i_c_y,
    input  logic [31:0] i_c_z,
    output logic        o_done,
    output logic [31:0] o_norm_x,
    output logic [31:0] o_norm_y,
    output logic [31:0] o_norm_z,
    output logic        o_degenerate
);
    import tun_pkg::*;

    logic [OUT_W-1:0] crd [9];
    t_div_word        div_w  [DIV_CELLS+1];
    t_sqrt_word       sqrt_w [SQRT_CELLS+1];
    logic             r_done;
    logic             r_degen;
    logic [OUT_W-1:0] r_norm [3];

    assign o_busy = 1'b0;
    assign crd = '{i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z};

    tun_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(i_start),
        .i_crd(crd), .o_word(div_w[0])
    );

    // Divide chain, one quotient bit per cell.
    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        tun_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_word(div_w[g]), .o_word(div_w[g+1])
        );
    end

    // Hand over the quotient as radicand.
    always_comb begin
        sqrt_w[0].vld   = div_w[DIV_CELLS].vld;
        sqrt_w[0].degen = div_w[DIV_CELLS].degen;
        sqrt_w[0].neg   = div_w[DIV_CELLS].neg;
        for (int l = 0; l < 3; l++) begin
            sqrt_w[0].rad[l]  = div_w[DIV_CELLS].quo[l];
            sqrt_w[0].rem[l]  = '0;
            sqrt_w[0].root[l] = '0;
        end
    end

    // Root chain, one root bit per cell.
    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        tun_sqrt_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_word(sqrt_w[g]), .o_word(sqrt_w[g+1])
        );
    end

    // Output register: apply sign, force zero on a degenerate triangle.
    always_ff @(posedge i_clk) begin
        logic [OUT_W-1:0] m;
        r_done  <= sqrt_w[SQRT_CELLS].vld;
        r_degen <= sqrt_w[SQRT_CELLS].degen;
        for (int l = 0; l < 3; l++) begin
            m = OUT_W'(sqrt_w[SQRT_CELLS].root[l]);
            if (sqrt_w[SQRT_CELLS].degen) begin
                r_norm[l] <= '0;
            end else begin
                r_norm[l] <= sqrt_w[SQRT_CELLS].neg[l] ? OUT_W'(-m) : m;
            end
        end
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end
    end

    assign o_done       = r_done;
    assign o_degenerate = r_degen;
    assign o_norm_x     = r_norm[0];
    assign o_norm_y     = r_norm[1];
    assign o_norm_z     = r_norm[2];

    // A degenerate result carries the zero vector.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |-> (o_norm_x == '0 && o_norm_y == '0 && o_norm_z == '0))
        else $error("degenerate result with nonzero normal");
    // The x component's root never exceeds one in magnitude; a zero-length word is overridden.
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sqrt_w[SQRT_CELLS].vld && !sqrt_w[SQRT_CELLS].degen)
        |-> (sqrt_w[SQRT_CELLS].root[0] <= (R_W'(1) << OUT_FRAC)))
        else $error("normal component above one");
    // The divide chain enters the root chain without losing words.
    a_chain_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_w[DIV_CELLS].vld |=> sqrt_w[1].vld)
        else $error("word lost between divide and root chains");
endmodule

// ===== verif/triangle_unit_normal_tb.sv =====
// Self-checking testbench for triangle_unit_normal: directed table plus random triangles.
// Depends on hdl/tun_pkg.sv and hdl/triangle_unit_normal.sv; predicts each normal itself.
module triangle_unit_normal_tb;
    import tun_pkg::*;

    localparam int LATENCY   = 100;
    localparam int CYCLE_CAP = 200000;
    localparam int N_RANDOM  = 900;
    localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
    localparam logic [31:0] MONE_Q30 = 32'hC000_0000;

    // One triangle: index 0, 1, 2 is x, y, z.
    typedef struct {
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [2:0][31:0] c;
    } t_tri;

    typedef struct packed {
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic        degen;
    } t_normal;

    // One row of the directed table; known is set where the answer is typed in.
    typedef struct {
        t_tri    tri_in;
        logic    known;
        t_normal want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [31:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic [31:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic [31:0] i_c_x = '0, i_c_y = '0, i_c_z = '0;
    logic        o_busy, o_done, o_degenerate;
    logic [31:0] o_norm_x, o_norm_y, o_norm_z;

    t_normal pending_normals[$];
    t_normal typed_normals[$];
    logic    typed_flags[$];
    int      error_count = 0;
    int      cycle_count = 0;

    triangle_unit_normal dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z),
        .i_c_x(i_c_x), .i_c_y(i_c_y), .i_c_z(i_c_z),
        .o_done(o_done), .o_norm_x(o_norm_x), .o_norm_y(o_norm_y),
        .o_norm_z(o_norm_z), .o_degenerate(o_degenerate)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Exact cross product, then each component as isqrt(n_i^2 * 2^60 / |n|^2).
    function automatic t_normal unit_normal(t_tri t);
        logic signed [67:0] u[3], v[3], nc[3];
        logic [199:0] sq[3], sum, num;
        logic [63:0]  quo, root, trial;
        logic [31:0]  comp[3];
        t_normal      res;
        for (int i = 0; i < 3; i++) begin
            u[i] = $signed({t.c[i][31], t.c[i]}) - $signed({t.b[i][31], t.b[i]});
            v[i] = $signed({t.a[i][31], t.a[i]}) - $signed({t.b[i][31], t.b[i]});
        end
        nc[0] = u[1] * v[2] - u[2] * v[1];
        nc[1] = u[2] * v[0] - u[0] * v[2];
        nc[2] = u[0] * v[1] - u[1] * v[0];
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            sq[i] = '0;
            sq[i][67:0] = (nc[i] < 0) ? -nc[i] : nc[i];
            sq[i] = sq[i] * sq[i];
            sum = sum + sq[i];
        end
        if (sum == 0) begin
            res = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            num = sq[i] << 60;
            quo = 64'(num / sum);
            root = '0;
            for (int k = 31; k >= 0; k--) begin
                trial = root | (64'd1 << k);
                if (trial * trial <= quo) root = trial;
            end
            comp[i] = (nc[i] < 0) ? 32'(-root) : root[31:0];
        end
        res = '{nx: comp[0], ny: comp[1], nz: comp[2], degen: 1'b0};
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // Accepted words: predict at the edge that takes them.
    always @(posedge i_clk) begin
        t_tri    t;
        t_normal p;
        if (i_rst_n && i_start && !o_busy) begin
            t.a = {i_a_z, i_a_y, i_a_x};
            t.b = {i_b_z, i_b_y, i_b_x};
            t.c = {i_c_z, i_c_y, i_c_x};
            p = unit_normal(t);
            if (typed_flags.size() > 0 && typed_flags.pop_front()) begin
                if (typed_normals[0] != p)
                    report_mismatch("typed row vs predictor", p.nz, typed_normals[0].nz);
                p = typed_normals[0];
            end
            if (typed_normals.size() > 0) void'(typed_normals.pop_front());
            pending_normals.insert(pending_normals.size(), p);
        end
    end

    // Result words: compare with the oldest expectation.
    always @(posedge i_clk) begin
        t_normal w;
        if (i_rst_n && o_done) begin
            if (pending_normals.size() == 0) begin
                report_mismatch("unexpected result word", o_norm_x, '0);
            end else begin
                w = pending_normals.pop_front();
                if (o_norm_x !== w.nx) report_mismatch("norm_x", o_norm_x, w.nx);
                if (o_norm_y !== w.ny) report_mismatch("norm_y", o_norm_y, w.ny);
                if (o_norm_z !== w.nz) report_mismatch("norm_z", o_norm_z, w.nz);
                if (o_degenerate !== w.degen)
                    report_mismatch("degenerate", 32'(o_degenerate), 32'(w.degen));
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("triangle_unit_normal verification failed");
            $finish;
        end
    end

    // Present one word and hold it until the block takes it.
    task automatic send_word(t_tri t, int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        {i_a_z, i_a_y, i_a_x} <= t.a;
        {i_b_z, i_b_y, i_b_x} <= t.b;
        {i_c_z, i_c_y, i_c_x} <= t.c;
        do @(posedge i_clk); while (o_busy);
    endtask

    function automatic logic [31:0] rand_coord(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8)) - 4) <<< $urandom_range(0, 16);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        int   kind, k;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            t.a[i] = rand_coord(kind % 4);
            t.b[i] = rand_coord(kind % 4);
            t.c[i] = rand_coord(kind % 4);
        end
        // Some triangles are made collinear on purpose.
        if (kind >= 8) begin
            k = $urandom_range(0, 6) - 3;
            for (int i = 0; i < 3; i++) begin
                t.a[i] = 32'($signed($urandom_range(0, 2000)) - 1000);
                t.b[i] = 32'($signed($urandom_range(0, 2000)) - 1000);
                t.c[i] = t.b[i] + 32'(k) * (t.a[i] - t.b[i]);
            end
        end
        return t;
    endfunction

    function automatic t_tri make_tri(logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
        t_tri t;
        t.a = {az, ay, ax};
        t.b = {bz, by, bx};
        t.c = {cz, cy, cx};
        return t;
    endfunction

    initial begin
        t_row    rows[$];
        t_normal zero_n, degen_n;
        int      idle_pct[4];
        logic [31:0] s, mx, mn;
        s  = 32'h0001_0000;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        zero_n  = '{nx: '0, ny: '0, nz: '0, degen: 1'b0};
        degen_n = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
        idle_pct = '{0, 59, 0, 35};

        // Directed table: degenerate triangles, axis-aligned normals, extremes.
        rows.insert(rows.size(), '{make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, degen_n});
        rows.insert(rows.size(), '{make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx), 1'b1,
                                   degen_n});
        rows.insert(rows.size(), '{make_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn), 1'b1,
                                   degen_n});
        rows.insert(rows.size(), '{make_tri(s, s, s, 0, 0, 0, 2 * s, 2 * s, 2 * s), 1'b1,
                                   degen_n});
        rows.insert(rows.size(), '{make_tri(mx, mx, mx, 0, 0, 0, mn, mn, mn), 1'b1,
                                   degen_n});
        rows.insert(rows.size(), '{make_tri(0, s, 0, 0, 0, 0, s, 0, 0), 1'b1,
                                   '{nx: '0, ny: '0, nz: ONE_Q30, degen: 1'b0}});
        rows.insert(rows.size(), '{make_tri(s, 0, 0, 0, 0, 0, 0, s, 0), 1'b1,
                                   '{nx: '0, ny: '0, nz: MONE_Q30, degen: 1'b0}});
        rows.insert(rows.size(), '{make_tri(0, 0, s, 0, 0, 0, 0, s, 0), 1'b1,
                                   '{nx: ONE_Q30, ny: '0, nz: '0, degen: 1'b0}});
        rows.insert(rows.size(), '{make_tri(s, 0, 0, 0, 0, 0, 0, 0, s), 1'b1,
                                   '{nx: '0, ny: ONE_Q30, nz: '0, degen: 1'b0}});
        rows.insert(rows.size(), '{make_tri(0, mx, 0, 0, 0, 0, mx, 0, 0), 1'b1,
                                   '{nx: '0, ny: '0, nz: ONE_Q30, degen: 1'b0}});
        rows.insert(rows.size(), '{make_tri(mx, mn, mx, mn, mx, mn, mx, mx, mn), 1'b0,
                                   zero_n});
        rows.insert(rows.size(), '{make_tri(mn, mn, mx, mx, mx, mn, mn, mx, mx), 1'b0,
                                   zero_n});
        rows.insert(rows.size(), '{make_tri(mx, 0, mn, mn, mx, 0, 0, mn, mx), 1'b0,
                                   zero_n});
        rows.insert(rows.size(), '{make_tri(1, 0, 0, 0, 0, 0, 0, 1, 1), 1'b0, zero_n});
        rows.insert(rows.size(), '{make_tri(-1, 2, -3, 4, -5, 6, -7, 8, 9), 1'b0, zero_n});
        rows.insert(rows.size(), '{make_tri(32'hFFFF_FFFF, 1, 0, 0, 32'hFFFF_FFFF, 1, 1, 0,
                                            32'hFFFF_FFFF), 1'b0, zero_n});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            typed_flags.insert(typed_flags.size(), rows[r].known);
            typed_normals.insert(typed_normals.size(), rows[r].want);
            send_word(rows[r].tri_in, 0);
        end
        i_start <= 1'b0;

        // Hold off until every directed result is back.
        wait (pending_normals.size() == 0);
        @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                typed_flags.insert(typed_flags.size(), 1'b0);
                typed_normals.insert(typed_normals.size(), zero_n);
                send_word(rand_tri(), idle_pct[ph]);
            end
            i_start <= 1'b0;
            if (ph == 1) begin
                wait (pending_normals.size() == 0);
                @(posedge i_clk);
            end
        end

        wait (pending_normals.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("triangle_unit_normal verification clean");
        end else begin
            $display("triangle_unit_normal verification failed");
        end
        $finish;
    end
endmodule

// ===== triangle_unit_normal.f =====
hdl/tun_pkg.sv
hdl/tun_div_cell.sv
hdl/tun_sqrt_cell.sv
hdl/tun_front.sv
hdl/triangle_unit_normal.sv
verif/triangle_unit_normal_tb.sv
